@@ rtl/core/syb_pkg.sv @@
package syb_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RED          = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENCY = 8'd3;

    // BT.709 limited-range coefficients, unsigned Q0.16
    localparam logic [23:0] K_Y_R  = 24'd11966;
    localparam logic [23:0] K_Y_G  = 24'd40254;
    localparam logic [23:0] K_Y_B  = 24'd4064;
    localparam logic [23:0] K_CB_R = 24'd6596;
    localparam logic [23:0] K_CB_G = 24'd22189;
    localparam logic [23:0] K_CB_B = 24'd28784;
    localparam logic [23:0] K_CR_R = 24'd28784;
    localparam logic [23:0] K_CR_G = 24'd26145;
    localparam logic [23:0] K_CR_B = 24'd2639;

    // Offsets in Q8.16
    localparam logic [23:0] LUMA_OFS   = 24'd16 << 16;
    localparam logic [23:0] CHROMA_OFS = 24'd128 << 16;

    // Blend weight scale: 255 * 255 * 129
    localparam int            W_W        = 23;
    localparam logic [W_W-1:0] BLEND_FULL = 23'd8388225;
    localparam int            BLEND_SHIFT = 23;
    localparam int            PROD_W      = W_W + 8;

    typedef struct packed {
        logic [7:0] coverage;
        logic [7:0] dest_luma;
        logic [7:0] dest_cb;
        logic [7:0] dest_cr;
        logic       chroma_site;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_luma;
        logic [7:0] out_cb;
        logic [7:0] out_cr;
        logic       chroma_written;
    } t_out_item;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_ovl_color;

endpackage

@@ rtl/core/subtitle_yuv_overlay_blend.sv @@
// Throughput: one item per cycle while i_out_ready is high; four register
// stages (opacity product, weight, blend multipliers, sum and select) each
// hand on one item a cycle, and back-pressure from i_out_ready stalls them.
// Reset (i_rst_n low at a clock edge) empties the pipeline and clears the
// overlay color and transparency registers to zero.
module subtitle_yuv_overlay_blend
    import syb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic [7:0] r_transp;
    logic [7:0] opacity;
    t_ovl_color color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
            r_transp <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RED:          r_red    <= i_cfg_data;
                REG_GREEN:        r_green  <= i_cfg_data;
                REG_BLUE:         r_blue   <= i_cfg_data;
                REG_TRANSPARENCY: r_transp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign opacity = 8'd255 - r_transp;

    syb_csc u_csc (
        .i_clk   (i_clk),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_color (color)
    );

    // Pipeline handshake: a stage loads when empty or when it drains
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4       = !r_v4 || i_out_ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: coverage * opacity
    t_in_item    r_s1_item;
    logic [15:0] r_s1_cov_op;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_item   <= i_in_item;
            r_s1_cov_op <= {8'd0, i_in_item.coverage} * {8'd0, opacity};
        end
    end

    // Stage 2: weight = cov_op * 129 and its complement
    t_in_item       r_s2_item;
    logic [W_W-1:0] r_s2_w;
    logic [W_W-1:0] r_s2_inv;
    logic [W_W-1:0] n_w;

    assign n_w = {r_s1_cov_op, 7'd0} + {7'd0, r_s1_cov_op};

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_item <= r_s1_item;
            r_s2_w    <= n_w;
            r_s2_inv  <= BLEND_FULL - n_w;
        end
    end

    // Stage 3: the six blend products
    t_in_item          r_s3_item;
    logic [PROD_W-1:0] r_s3_y_src, r_s3_y_dst;
    logic [PROD_W-1:0] r_s3_cb_src, r_s3_cb_dst;
    logic [PROD_W-1:0] r_s3_cr_src, r_s3_cr_dst;
    logic [PROD_W-1:0] w_ext, inv_ext;

    assign w_ext   = {8'd0, r_s2_w};
    assign inv_ext = {8'd0, r_s2_inv};

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_item   <= r_s2_item;
            r_s3_y_src  <= w_ext   * {{(PROD_W-8){1'b0}}, color.y};
            r_s3_y_dst  <= inv_ext * {{(PROD_W-8){1'b0}}, r_s2_item.dest_luma};
            r_s3_cb_src <= w_ext   * {{(PROD_W-8){1'b0}}, color.cb};
            r_s3_cb_dst <= inv_ext * {{(PROD_W-8){1'b0}}, r_s2_item.dest_cb};
            r_s3_cr_src <= w_ext   * {{(PROD_W-8){1'b0}}, color.cr};
            r_s3_cr_dst <= inv_ext * {{(PROD_W-8){1'b0}}, r_s2_item.dest_cr};
        end
    end

    // Stage 4: sum, floor by the blend shift, chroma select
    // Sums stay at or below 255 * BLEND_FULL < 2^31, so no carry out is lost
    logic [PROD_W-1:0] sum_y, sum_cb, sum_cr;
    t_out_item         n_out;
    t_out_item         r_out;

    assign sum_y  = r_s3_y_src  + r_s3_y_dst;
    assign sum_cb = r_s3_cb_src + r_s3_cb_dst;
    assign sum_cr = r_s3_cr_src + r_s3_cr_dst;

    always_comb begin
        n_out.out_luma = sum_y[BLEND_SHIFT +: 8];
        if (r_s3_item.chroma_site) begin
            n_out.out_cb         = sum_cb[BLEND_SHIFT +: 8];
            n_out.out_cr         = sum_cr[BLEND_SHIFT +: 8];
            n_out.chroma_written = 1'b1;
        end else begin
            n_out.out_cb         = r_s3_item.dest_cb;
            n_out.out_cr         = r_s3_item.dest_cr;
            n_out.chroma_written = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/syb_csc.sv @@
module syb_csc
    import syb_pkg::*;
(
    input  logic       i_clk,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output t_ovl_color o_color
);

    logic [23:0] r24;
    logic [23:0] g24;
    logic [23:0] b24;
    logic [23:0] sum_y;
    logic [23:0] sum_cb;
    logic [23:0] sum_cr;
    t_ovl_color  r_color;

    assign r24 = {16'd0, i_red};
    assign g24 = {16'd0, i_green};
    assign b24 = {16'd0, i_blue};

    // Sums stay positive and below 2^24, so modulo-2^24 arithmetic is exact
    assign sum_y  = K_Y_R * r24 + K_Y_G * g24 + K_Y_B * b24 + LUMA_OFS;
    assign sum_cb = CHROMA_OFS + K_CB_B * b24 - K_CB_R * r24 - K_CB_G * g24;
    assign sum_cr = CHROMA_OFS + K_CR_R * r24 - K_CR_G * g24 - K_CR_B * b24;

    // Color only changes with configuration; register once per cycle
    always_ff @(posedge i_clk) begin
        r_color.y  <= sum_y[23:16];
        r_color.cb <= sum_cb[23:16];
        r_color.cr <= sum_cr[23:16];
    end

    assign o_color = r_color;

endmodule

@@ tb/tb_subtitle_yuv_overlay_blend.sv @@
`timescale 1ns / 1ps

module tb_subtitle_yuv_overlay_blend;
    import syb_pkg::*;

    // Unmapped register indexes, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX     = 8'hFF;

    localparam int RANDOM_PIXELS = 1800;
    localparam int PIPE_SLACK    = 8;    // extra wait after the scoreboard empties

    // Blend scoreboard: holds its own copy of the overlay registers
    class overlay_scoreboard;
        // BT.709 limited-range matrix, Q0.16
        localparam int unsigned CY_R  = 11966;
        localparam int unsigned CY_G  = 40254;
        localparam int unsigned CY_B  = 4064;
        localparam int unsigned CCB_R = 6596;
        localparam int unsigned CCB_G = 22189;
        localparam int unsigned CCB_B = 28784;
        localparam int unsigned CCR_R = 28784;
        localparam int unsigned CCR_G = 26145;
        localparam int unsigned CCR_B = 2639;
        localparam int unsigned Y_BIAS    = 16 << 16;
        localparam int unsigned C_BIAS    = 128 << 16;
        localparam int unsigned MIX_TOTAL = 255 * 255 * 129;
        localparam int          MIX_SHIFT = 23;

        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  transp;
        t_out_item   blend_q[$];
        int unsigned mismatches;

        function new();
            red        = '0;
            green      = '0;
            blue       = '0;
            transp     = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_RED:          red    = val;
                REG_GREEN:        green  = val;
                REG_BLUE:         blue   = val;
                REG_TRANSPARENCY: transp = val;
                default: ;
            endcase
        endfunction

        // (w*src + (total-w)*dst) >> 23, low byte kept
        function logic [7:0] mix(int unsigned w, logic [7:0] src, logic [7:0] dst);
            longint unsigned a;
            longint unsigned b;
            longint unsigned sum;
            a   = w;
            a   = a * src;
            b   = MIX_TOTAL - w;
            b   = b * dst;
            sum = (a + b) >> MIX_SHIFT;
            return sum[7:0];
        endfunction

        function t_out_item blend_pixel(t_in_item px);
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned acc;
            int unsigned w;
            logic [7:0]  ovl_y;
            logic [7:0]  ovl_cb;
            logic [7:0]  ovl_cr;
            t_out_item   res;
            r = red;
            g = green;
            b = blue;
            // overlay color to YCbCr, floored
            acc    = (CY_R * r + CY_G * g + CY_B * b + Y_BIAS) >> 16;
            ovl_y  = acc[7:0];
            acc    = (C_BIAS + CCB_B * b - CCB_R * r - CCB_G * g) >> 16;
            ovl_cb = acc[7:0];
            acc    = (C_BIAS + CCR_R * r - CCR_G * g - CCR_B * b) >> 16;
            ovl_cr = acc[7:0];
            w = px.coverage;
            w = w * (255 - int'(transp)) * 129;
            res.out_luma = mix(w, ovl_y, px.dest_luma);
            // chroma only blended at chroma sites
            if (px.chroma_site) begin
                res.out_cb         = mix(w, ovl_cb, px.dest_cb);
                res.out_cr         = mix(w, ovl_cr, px.dest_cr);
                res.chroma_written = 1'b1;
            end else begin
                res.out_cb         = px.dest_cb;
                res.out_cr         = px.dest_cr;
                res.chroma_written = 1'b0;
            end
            return res;
        endfunction

        function void note_pixel(t_in_item px);
            blend_q.push_back(blend_pixel(px));
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item exp_px;
            if (blend_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: Y=%0d Cb=%0d Cr=%0d cw=%0b",
                             got.out_luma, got.out_cb, got.out_cr, got.chroma_written);
                return;
            end
            exp_px = blend_q.pop_front();
            if (got.out_luma != exp_px.out_luma || got.out_cb != exp_px.out_cb ||
                got.out_cr != exp_px.out_cr ||
                got.chroma_written != exp_px.chroma_written) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: exp Y=%0d Cb=%0d Cr=%0d cw=%0b, ",
                              "got Y=%0d Cb=%0d Cr=%0d cw=%0b"},
                             exp_px.out_luma, exp_px.out_cb, exp_px.out_cr,
                             exp_px.chroma_written, got.out_luma, got.out_cb,
                             got.out_cr, got.chroma_written);
            end
        endfunction

        function int unsigned pending();
            return blend_q.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    overlay_scoreboard sb = new();
    bit src_burst = 1'b0;
    int sink_hold = 0;

    subtitle_yuv_overlay_blend uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_pixel(i_in_item);
            if (o_out_valid && i_out_ready)
                sb.check_pixel(o_out_item);
        end
    end

    // Sink back-pressure: runs of ready, short stalls, the odd long one
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            i_out_ready <= 1'b1;
            sink_hold   <= $urandom_range(0, 20);
        end else begin
            i_out_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                sink_hold <= $urandom_range(10, 40);
            else
                sink_hold <= $urandom_range(0, 2);
        end
    end

    function automatic int pick_gap();
        int r;
        if (src_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input t_in_item px);
        int gap;
        gap = pick_gap();
        i_in_item  <= px;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pix(input logic [7:0] cov, input logic [7:0] y, input logic [7:0] cb,
                       input logic [7:0] cr, input logic site);
        t_in_item px;
        px = '{coverage: cov, dest_luma: y, dest_cb: cb, dest_cr: cr, chroma_site: site};
        send_pixel(px);
    endtask

    // Config write; valid is left high so back-to-back writes stay clean
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_overlay(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] t, input bit junk);
        cfg_put(REG_RED, r);
        cfg_put(REG_GREEN, g);
        cfg_put(REG_BLUE, b);
        cfg_put(REG_TRANSPARENCY, t);
        // write to an unmapped index must not disturb anything
        if (junk)
            cfg_put(CFG_IDX_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_INDEX)),
                    CFG_DAT_W'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every pending pixel to come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int sent;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset colors: black, fully opaque
        pix(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        pix(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        pix(8'd0, 8'd200, 8'd50, 8'd90, 1'b1);
        pix(8'd255, 8'd77, 8'd66, 8'd55, 1'b0);
        pix(8'd1, 8'd255, 8'd0, 8'd255, 1'b1);
        drain();

        // white, opaque, with a stray write to an unmapped index
        set_overlay(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        cfg_put(REG_LAST_INDEX, 8'hAA);
        i_cfg_valid <= 1'b0;
        pix(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        pix(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        pix(8'd128, 8'd16, 8'd128, 8'd128, 1'b1);
        pix(8'd254, 8'd235, 8'd240, 8'd16, 1'b1);
        pix(8'd0, 8'd10, 8'd250, 8'd5, 1'b1);
        drain();

        // red, fully transparent: zero weight, each blended nonzero value comes out one below destination
        set_overlay(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        pix(8'd255, 8'd10, 8'd20, 8'd30, 1'b1);
        pix(8'd255, 8'd255, 8'd0, 8'd255, 1'b0);
        pix(8'd7, 8'd0, 8'd255, 8'd0, 1'b1);
        drain();

        // green, nearly opaque
        set_overlay(8'd0, 8'd255, 8'd0, 8'd1, 1'b0);
        pix(8'd255, 8'd128, 8'd128, 8'd128, 1'b1);
        pix(8'd64, 8'd255, 8'd255, 8'd255, 1'b1);
        pix(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        drain();

        // blue, half transparent
        set_overlay(8'd0, 8'd0, 8'd255, 8'd128, 1'b1);
        pix(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
        pix(8'd200, 8'd100, 8'd0, 8'd255, 1'b1);
        pix(8'd255, 8'd255, 8'd128, 8'd64, 1'b0);
        drain();

        // random phases, each with a fresh overlay setting
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            set_overlay(pick_level(), pick_level(), pick_level(), pick_level(),
                        $urandom_range(0, 3) == 0);
            src_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 150);
            repeat (n) begin
                pix(pick_level(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            sent += n;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/syb_pkg.sv
rtl/core/syb_csc.sv
rtl/core/subtitle_yuv_overlay_blend.sv
tb/tb_subtitle_yuv_overlay_blend.sv
